[rtl/tkm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_pkg: shared types and constants
// Sizes of the sample store, payload structs and the control/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tkm_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int PART_W      = 16;
   localparam int SQ_W        = 2 * PART_W - 1;
   localparam int MAG_W       = 2 * PART_W;
   localparam int KEEP_W      = 7;

   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

   typedef struct packed {
      logic signed [PART_W-1:0] real_part;
      logic signed [PART_W-1:0] imag_part;
      logic                     last_sample;
   } req_type;

   typedef struct packed {
      logic keep_flag;
      logic last_flag;
   } rsp_type;

   typedef struct packed {
      logic capture;   // latch the request beat
      logic square;    // register both squares
      logic store;     // write magnitude, bump fill count
      logic fetch_i;   // read the sample under test
      logic latch_i;   // hold it, clear scan index and rank count
      logic scan;      // read next stored sample for comparison
      logic emit;      // register one mask beat, advance sample index
      logic finish;    // empty the block
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_sample;  // captured beat closes the block
      logic scan_done;    // scan index reached the final stored sample
      logic last_item;    // sample index reached the final stored sample
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/tkm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_dp: magnitude store and rank datapath
// Squares each sample, stores it, then ranks every stored sample against all
// others with a single comparator and registers one mask beat per sample.
// ----------------------------------------------------------------------------
module tkm_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire tkm_pkg::req_type        req_data,
   input  wire [tkm_pkg::KEEP_W-1:0]    keep_count,
   input  wire tkm_pkg::ctrl_cmd_type   cmd,
   output tkm_pkg::dp_status_type       status,
   output logic                         rsp_strobe,
   output tkm_pkg::rsp_type             rsp_data
);

   logic [tkm_pkg::MAG_W-1:0]       mem [tkm_pkg::MAX_SAMPLES];

   tkm_pkg::req_type                req_ff;
   logic [tkm_pkg::SQ_W-1:0]        sq_re_ff;
   logic [tkm_pkg::SQ_W-1:0]        sq_im_ff;
   logic signed [tkm_pkg::MAG_W-1:0] prod_re;
   logic signed [tkm_pkg::MAG_W-1:0] prod_im;
   logic [tkm_pkg::MAG_W-1:0]       mag_sum;

   logic [tkm_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [tkm_pkg::ADDR_W-1:0]      idx_i_ff, idx_i_in;
   logic [tkm_pkg::ADDR_W-1:0]      idx_j_ff, idx_j_in;
   logic [tkm_pkg::CNT_W-1:0]       larger_ff, larger_in;
   logic                            cmp_valid_ff;
   logic                            cmp_larger;
   logic [tkm_pkg::MAG_W-1:0]       rd_data_ff;
   logic [tkm_pkg::MAG_W-1:0]       mag_i_ff;
   logic [tkm_pkg::ADDR_W-1:0]      rd_addr;
   logic                            full;
   logic [tkm_pkg::CNT_W-1:0]       last_pos;

   logic                            rsp_valid_ff;
   tkm_pkg::rsp_type                rsp_ff;

   assign prod_re = req_ff.real_part * req_ff.real_part;
   assign prod_im = req_ff.imag_part * req_ff.imag_part;
   assign mag_sum = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

   assign full     = (count_ff == tkm_pkg::CNT_W'(tkm_pkg::MAX_SAMPLES));
   assign last_pos = count_ff - tkm_pkg::CNT_W'(1);
   assign rd_addr  = cmd.fetch_i ? idx_i_ff : idx_j_ff;

   assign cmp_larger = cmp_valid_ff && (rd_data_ff > mag_i_ff);

   assign status.last_sample = req_ff.last_sample;
   assign status.scan_done   = ({1'b0, idx_j_ff} == last_pos);
   assign status.last_item   = ({1'b0, idx_i_ff} == last_pos);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.square) begin
         sq_re_ff <= prod_re[tkm_pkg::SQ_W-1:0];
         sq_im_ff <= prod_im[tkm_pkg::SQ_W-1:0];
      end
      if (cmd.latch_i) begin
         mag_i_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_ff.keep_flag <= ({1'b0, larger_ff} < {1'b0, keep_count});
         rsp_ff.last_flag <= status.last_item;
      end
   end

   // sample store, registered read
   always_ff @(posedge clock) begin
      if (cmd.store && !full) begin
         mem[count_ff[tkm_pkg::ADDR_W-1:0]] <= mag_sum;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in  = count_ff;
      idx_i_in  = idx_i_ff;
      idx_j_in  = idx_j_ff;
      larger_in = larger_ff;
      if (cmd.store && !full) begin
         count_in = count_ff + tkm_pkg::CNT_W'(1);
      end
      if (cmd.latch_i) begin
         idx_j_in  = '0;
         larger_in = '0;
      end
      if (cmd.scan) begin
         idx_j_in = idx_j_ff + tkm_pkg::ADDR_W'(1);
      end
      if (cmp_larger) begin
         larger_in = larger_ff + tkm_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
         idx_i_in = idx_i_ff + tkm_pkg::ADDR_W'(1);
      end
      if (cmd.finish) begin
         count_in = '0;
         idx_i_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         larger_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         larger_ff    <= larger_in;
         cmp_valid_ff <= cmd.scan;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

[rtl/tkm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_ctrl: sequencer for load and ranking
// Steps each sample through capture, square and store, then on the closing
// beat walks every stored sample through fetch, scan and emit.
// ----------------------------------------------------------------------------
module tkm_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire tkm_pkg::dp_status_type  status,
   output tkm_pkg::ctrl_cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_STORE  = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_LATCH  = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_DRAIN  = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.last_sample ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            cmd.fetch_i = 1'b1;
            state_in    = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch_i = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the final compare land in the rank count
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last_item) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/top_k_magnitude_mask_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A sample that does not close the block steps through capture, square and
// store; a closing sample then walks each of the n stored samples through
// fetch, scan and emit, each mask beat paced by the single store read port
// that feeds the one rank comparator. Mask beats appear in the cycle after
// their emit state. The receiver cannot stall; beats are never back to back.
// Synchronous reset empties the block, sets keep_count to 1, idles the FSM.
// ----------------------------------------------------------------------------
// top_k_magnitude_mask_unit: top-k magnitude mask
// Loads complex samples and, on the closing sample, emits one keep bit per
// sample in input order; samples tied with the k-th largest are all kept.
// ----------------------------------------------------------------------------
module top_k_magnitude_mask_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire tkm_pkg::req_type      req_data,
   output logic                       rsp_strobe,
   output tkm_pkg::rsp_type           rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [tkm_pkg::KEEP_W-1:0]  csr_data
);

   tkm_pkg::ctrl_cmd_type          cmd;
   tkm_pkg::dp_status_type         status;
   logic [tkm_pkg::KEEP_W-1:0]     keep_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= tkm_pkg::KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_count_ff <= csr_data;
      end
   end

   tkm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tkm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .keep_count (keep_count_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/tkm_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_chk: port-level checks
// Watches the top-level ports for sequencing slips between load and mask.
// ----------------------------------------------------------------------------
module tkm_chk (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input wire                    rsp_strobe,
   input wire tkm_pkg::rsp_type  rsp_data
);

   // mask beats are never adjacent
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("mask beats back to back");

   // a mask beat follows a busy cycle
   a_strobe_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("mask beat without preceding work");

   // the final mask beat leaves the block idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_flag |-> !busy)
      else $error("block still busy after final mask beat");

   // an accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_strobe)
      else $error("mask beat right after reset");

endmodule

bind top_k_magnitude_mask_unit tkm_chk u_tkm_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
